// ===== src/rcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcd_pkg;

    localparam int WORD_W = 32;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 3;

    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic signed [WORD_W-1:0] word_t;

    localparam req_t REQ_INS_FRONT = 3'd0;
    localparam req_t REQ_INS_REAR  = 3'd1;
    localparam req_t REQ_DEL_FRONT = 3'd2;
    localparam req_t REQ_DEL_REAR  = 3'd3;
    localparam req_t REQ_DISPLAY   = 3'd4;

    localparam status_t STAT_OK          = 3'd0;
    localparam status_t STAT_OVERFLOW    = 3'd1;
    localparam status_t STAT_UNDERFLOW   = 3'd2;
    localparam status_t STAT_NOT_ALLOWED = 3'd3;
    localparam status_t STAT_EMPTY       = 3'd4;

    localparam logic MODE_INPUT_RESTRICTED  = 1'b0;
    localparam logic MODE_OUTPUT_RESTRICTED = 1'b1;

endpackage

`default_nettype wire

// ===== src/rcd_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcd_ring
    import rcd_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire word_t                    wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output word_t                         rd_data
);

    word_t mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/restricted_circular_deque.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake              Word
// s_       in   s_valid / s_ready      s_req_type, s_element_value
// m_       out  m_valid / m_ready      m_status, m_data_word, m_last_of_run
// cfg_     in   cfg_valid / cfg_ready  cfg_data (restriction mode)
//
// Inserts, refused requests and error answers are registered straight to m_; with
// m_ready high a new such request is taken every cycle. A delete does one ring
// read from the registered ring port; a display does one ring read per word.
// Synchronous reset clears pointers, count, mode and control; ring contents
// are not cleared. A stall on m_ (m_ready low) holds the walk and the input.

module restricted_circular_deque
    import rcd_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire req_t    s_req_type,
    input  wire word_t   s_element_value,
    output logic         m_valid,
    input  wire logic    m_ready,
    output status_t      m_status,
    output word_t        m_data_word,
    output logic         m_last_of_run,
    input  wire logic    cfg_valid,
    output logic         cfg_ready,
    input  wire logic    cfg_data
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    typedef logic [IW-1:0] idx_t;
    typedef logic [CW-1:0] cnt_t;

    function automatic idx_t step_up(input idx_t i);
        return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t step_down(input idx_t i);
        return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
    endfunction

    logic    state_reg, state_next;
    logic    mode_reg;
    idx_t    front_reg, front_next;
    idx_t    rear_reg, rear_next;
    cnt_t    occ_reg, occ_next;
    idx_t    walk_reg, walk_next;
    cnt_t    left_reg, left_next;
    logic    m_valid_reg, m_valid_next;
    status_t m_status_reg, m_status_next;
    word_t   m_data_word_reg, m_data_word_next;
    logic    m_last_reg, m_last_next;

    logic    wr_en, rd_en;
    idx_t    wr_addr, rd_addr;
    word_t   rd_data;

    logic    out_free, accept, refused;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = aresetn && (state_reg == S_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = aresetn;

    assign refused = (s_req_type > REQ_DISPLAY)
        || (s_req_type == REQ_INS_FRONT && mode_reg == MODE_INPUT_RESTRICTED)
        || (s_req_type == REQ_DEL_REAR && mode_reg == MODE_OUTPUT_RESTRICTED);

    always_comb begin
        state_next       = state_reg;
        front_next       = front_reg;
        rear_next        = rear_reg;
        occ_next         = occ_reg;
        walk_next        = walk_reg;
        left_next        = left_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_status_next    = m_status_reg;
        m_data_word_next = m_data_word_reg;
        m_last_next      = m_last_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        rd_en            = 1'b0;
        rd_addr          = front_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = STAT_OK;
                    m_data_word_next = '0;
                    m_last_next      = 1'b1;
                    if (refused) begin
                        m_status_next = STAT_NOT_ALLOWED;
                    end else begin
                        case (s_req_type)
                            REQ_INS_FRONT, REQ_INS_REAR: begin
                                if (occ_reg == cnt_t'(DEPTH)) begin
                                    m_status_next = STAT_OVERFLOW;
                                end else begin
                                    wr_en    = 1'b1;
                                    occ_next = cnt_t'(occ_reg + 1'b1);
                                    if (occ_reg == '0) begin
                                        front_next = '0;
                                        rear_next  = '0;
                                        wr_addr    = '0;
                                    end else if (s_req_type == REQ_INS_FRONT) begin
                                        front_next = step_down(front_reg);
                                        wr_addr    = step_down(front_reg);
                                    end else begin
                                        rear_next = step_up(rear_reg);
                                        wr_addr   = step_up(rear_reg);
                                    end
                                end
                            end
                            REQ_DEL_FRONT, REQ_DEL_REAR: begin
                                if (occ_reg == '0) begin
                                    m_status_next = STAT_UNDERFLOW;
                                end else begin
                                    // word comes back next cycle
                                    m_valid_next = 1'b0;
                                    rd_en        = 1'b1;
                                    left_next    = '0;
                                    state_next   = S_WALK;
                                    occ_next     = cnt_t'(occ_reg - 1'b1);
                                    if (s_req_type == REQ_DEL_FRONT) begin
                                        rd_addr    = front_reg;
                                        front_next = step_up(front_reg);
                                    end else begin
                                        rd_addr   = rear_reg;
                                        rear_next = step_down(rear_reg);
                                    end
                                    if (occ_reg == cnt_t'(1)) begin
                                        front_next = '0;
                                        rear_next  = '0;
                                    end
                                end
                            end
                            REQ_DISPLAY: begin
                                if (occ_reg == '0) begin
                                    m_status_next = STAT_EMPTY;
                                end else begin
                                    m_valid_next = 1'b0;
                                    rd_en        = 1'b1;
                                    rd_addr      = front_reg;
                                    walk_next    = step_up(front_reg);
                                    left_next    = cnt_t'(occ_reg - 1'b1);
                                    state_next   = S_WALK;
                                end
                            end
                            default: begin
                                m_status_next = STAT_NOT_ALLOWED;
                            end
                        endcase
                    end
                end
            end
            S_WALK: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = STAT_OK;
                    m_data_word_next = rd_data;
                    m_last_next      = (left_reg == '0);
                    if (left_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        rd_en     = 1'b1;
                        rd_addr   = walk_reg;
                        walk_next = step_up(walk_reg);
                        left_next = cnt_t'(left_reg - 1'b1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_INPUT_RESTRICTED;
            front_reg   <= '0;
            rear_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            rear_reg    <= rear_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        walk_reg        <= walk_next;
        left_reg        <= left_next;
        m_status_reg    <= m_status_next;
        m_data_word_reg <= m_data_word_next;
        m_last_reg      <= m_last_next;
    end

    rcd_ring #(
        .DEPTH(DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_element_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_data_word   = m_data_word_reg;
    assign m_last_of_run = m_last_reg;

endmodule

`default_nettype wire
